// File: rtl/fpba_pkg.sv
// Shared types and constants for the flux PLL bit assembler.
`default_nettype none
package fpba_pkg;

    localparam int INTERVAL_W = 16;
    localparam int CELL_W     = 24;
    localparam int GAIN_W     = 16;
    localparam int PHASE_W    = 26;
    localparam int COUNT_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 104;

    localparam logic [CELL_W-1:0] CLOCK_MIN = 24'd256;
    localparam logic [CELL_W-1:0] CLOCK_MAX = 24'hFF_FFFF;

    localparam logic [CELL_W-1:0] INITIAL_CELL_RST = 24'd12288;
    localparam logic [GAIN_W-1:0] FREQ_GAIN_RST    = 16'd655;
    localparam logic [GAIN_W-1:0] PHASE_GAIN_RST   = 16'd3277;

    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_CELL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FREQ_GAIN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_GAIN   = 2'd2;

    typedef struct packed {
        logic [COUNT_W-1:0] weak_total;
        logic [COUNT_W-1:0] bits_total;
        logic [CELL_W-1:0]  cell_clock;
        logic               window_ok;
        logic [1:0]         cell_count;
        logic [7:0]         data_byte;
        logic               byte_ready;
    } fpba_result_t;

endpackage
`default_nettype wire

// File: rtl/flux_pll_bit_assembler.sv
// Flux interval PLL data separator: rounds intervals to cells and assembles bytes.
// Each result is registered into the output buffer when its item is accepted.
// Throughput: one item per cycle while s_tready is high; the phase/clock loop (add, cell compare,
//   error subtract, Q0.16 gain multiply, clamp) is combinational between the loop registers.
// A two-entry output buffer keeps s_tready high for one stalled result.
// aresetn (synchronous, active low) restores the registers to their defaults,
//   loads the cell clock from the initial cell default and clears phase, byte and counters.
`default_nettype none
module flux_pll_bit_assembler #(
    parameter int MAX_CELLS = 3
) (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    // config write channel
    input  wire                                   cfg_valid,
    output logic                                  cfg_ready,
    input  wire  [fpba_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire  [fpba_pkg::CELL_W-1:0]           cfg_data,
    // input items
    input  wire                                   s_tvalid,
    output logic                                  s_tready,
    input  wire  [fpba_pkg::S_TDATA_W-1:0]        s_tdata,   // [15:0] interval
    input  wire                                   s_tuser,   // [0] track_start
    // result items
    output logic                                  m_tvalid,
    input  wire                                   m_tready,
    // [7:0] data_byte, [9:8] cell_count, [10] window_ok, [34:11] cell_clock,
    // [66:35] bits_total, [98:67] weak_total, [103:99] zero
    output logic [fpba_pkg::M_TDATA_W-1:0]        m_tdata,
    output logic                                  m_tuser    // [0] byte_ready
);
    import fpba_pkg::*;

    localparam int CW = $clog2(MAX_CELLS + 1);       // cell count width
    localparam int WW = PHASE_W + CW;                // signed phase/error width
    localparam int AW = 8 + MAX_CELLS;               // byte assembly window
    localparam int FW = $clog2(8 + MAX_CELLS);       // fill count after append

    // configuration
    logic [CELL_W-1:0] init_cell_reg, init_cell_next;
    logic [GAIN_W-1:0] freq_gain_reg, freq_gain_next;
    logic [GAIN_W-1:0] phase_gain_reg, phase_gain_next;

    // loop state
    logic signed [PHASE_W-1:0] phase_reg, phase_next;
    logic [CELL_W-1:0]         clock_reg, clock_next;
    logic [7:0]                byte_acc_reg, byte_acc_next;
    logic [2:0]                fill_reg, fill_next;
    logic [COUNT_W-1:0]        bits_reg, bits_next;
    logic [COUNT_W-1:0]        weak_reg, weak_next;

    // output buffer
    logic         m_valid_reg, m_valid_next;
    logic         skid_valid_reg, skid_valid_next;
    fpba_result_t m_data_reg, skid_data_reg;
    fpba_result_t result;

    logic s_accept;

    // working values
    logic signed [PHASE_W-1:0] phase_cur;
    logic [CELL_W-1:0]         clock_cur;
    logic [7:0]                byte_acc_cur;
    logic [2:0]                fill_cur;
    logic [COUNT_W-1:0]        bits_cur;
    logic [COUNT_W-1:0]        weak_cur;
    logic [INTERVAL_W-1:0]     interval;

    logic signed [WW-1:0]   clk_w;
    logic signed [WW-1:0]   phase_w;
    logic signed [WW:0]     phase_x2;
    logic signed [WW:0]     thresh;
    logic [CW-1:0]          cells;
    logic signed [WW-1:0]   err;
    logic [WW-1:0]          err_abs;
    logic                   win;
    logic [WW+GAIN_W-1:0]   freq_prod, phase_prod;
    logic [WW-1:0]          freq_corr, phase_corr;
    logic signed [WW+1:0]   clock_upd;
    logic signed [WW:0]     phase_new;
    logic [COUNT_W:0]       bits_sum;
    logic [COUNT_W:0]       weak_sum;
    logic [AW-1:0]          wide;
    logic [FW-1:0]          fill_sum;
    logic [FW-1:0]          extra;
    logic [AW-1:0]          keep_mask;
    logic                   byte_done;
    logic [7:0]             byte_val;

    assign cfg_ready = 1'b1;
    assign s_tready  = !skid_valid_reg;
    assign s_accept  = s_tvalid && s_tready;
    assign interval  = s_tdata[INTERVAL_W-1:0];

    always_comb begin
        init_cell_next  = init_cell_reg;
        freq_gain_next  = freq_gain_reg;
        phase_gain_next = phase_gain_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_INITIAL_CELL: init_cell_next  = cfg_data;
                REG_FREQ_GAIN:    freq_gain_next  = cfg_data[GAIN_W-1:0];
                REG_PHASE_GAIN:   phase_gain_next = cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // track start works from a freshly loaded state
    always_comb begin
        if (s_tuser) begin
            phase_cur    = '0;
            clock_cur    = (init_cell_reg < CLOCK_MIN) ? CLOCK_MIN : init_cell_reg;
            byte_acc_cur = '0;
            fill_cur     = '0;
            bits_cur     = '0;
            weak_cur     = '0;
        end else begin
            phase_cur    = phase_reg;
            clock_cur    = clock_reg;
            byte_acc_cur = byte_acc_reg;
            fill_cur     = fill_reg;
            bits_cur     = bits_reg;
            weak_cur     = weak_reg;
        end
    end

    // cell rounding: thresholds at 1.5, 2.5, ... cells rise with k, so count hits
    always_comb begin
        clk_w    = $signed({{(WW-CELL_W){1'b0}}, clock_cur});
        phase_w  = WW'(phase_cur) + $signed({{(WW-CELL_W){1'b0}}, interval, 8'h00});
        phase_x2 = (WW+1)'(phase_w) <<< 1;
        cells    = CW'(1);
        thresh   = '0;
        for (int k = 1; k < MAX_CELLS; k++) begin
            thresh = (WW+1)'(2 * k + 1) * (WW+1)'(clk_w);
            if (phase_x2 >= thresh) begin
                cells = CW'(k + 1);
            end
        end
        err     = phase_w - $signed({{(WW-CW){1'b0}}, cells}) * clk_w;
        err_abs = err[WW-1] ? WW'(-err) : WW'(err);
        win     = {err_abs, 1'b0} < (WW+1)'(init_cell_reg);
    end

    // gain products, rounded half away from zero
    always_comb begin
        freq_prod  = (WW+GAIN_W)'(err_abs) * (WW+GAIN_W)'(freq_gain_reg)
                     + (WW+GAIN_W)'(32768);
        phase_prod = (WW+GAIN_W)'(err_abs) * (WW+GAIN_W)'(phase_gain_reg)
                     + (WW+GAIN_W)'(32768);
        freq_corr  = freq_prod[WW+GAIN_W-1:GAIN_W];
        phase_corr = phase_prod[WW+GAIN_W-1:GAIN_W];

        if (err[WW-1]) begin
            clock_upd = $signed({2'b00, clk_w}) - $signed({2'b00, freq_corr});
            phase_new = -$signed({1'b0, phase_corr});
        end else begin
            clock_upd = $signed({2'b00, clk_w}) + $signed({2'b00, freq_corr});
            phase_new = $signed({1'b0, phase_corr});
        end

        if (clock_upd < $signed({{(WW+2-CELL_W){1'b0}}, CLOCK_MIN})) begin
            clock_next = CLOCK_MIN;
        end else if (clock_upd > $signed({{(WW+2-CELL_W){1'b0}}, CLOCK_MAX})) begin
            clock_next = CLOCK_MAX;
        end else begin
            clock_next = clock_upd[CELL_W-1:0];
        end

        if (phase_new > (WW+1)'($signed({1'b0, {(PHASE_W-1){1'b1}}}))) begin
            phase_next = {1'b0, {(PHASE_W-1){1'b1}}};
        end else if (phase_new < (WW+1)'($signed({1'b1, {(PHASE_W-1){1'b0}}}))) begin
            phase_next = {1'b1, {(PHASE_W-1){1'b0}}};
        end else begin
            phase_next = phase_new[PHASE_W-1:0];
        end
    end

    // saturating counters
    always_comb begin
        bits_sum  = {1'b0, bits_cur} + (COUNT_W+1)'(cells);
        weak_sum  = {1'b0, weak_cur} + (COUNT_W+1)'(!win);
        bits_next = bits_sum[COUNT_W] ? {COUNT_W{1'b1}} : bits_sum[COUNT_W-1:0];
        weak_next = weak_sum[COUNT_W] ? {COUNT_W{1'b1}} : weak_sum[COUNT_W-1:0];
    end

    // byte assembly: append cells-1 zeros and a one; at most one byte per item
    always_comb begin
        wide      = (AW'(byte_acc_cur) << cells) | AW'(1);
        fill_sum  = FW'(fill_cur) + FW'(cells);
        byte_done = fill_sum >= FW'(8);
        extra     = byte_done ? fill_sum - FW'(8) : '0;
        keep_mask = (AW'(1) << extra) - AW'(1);
        if (byte_done) begin
            byte_val      = 8'(wide >> extra);
            byte_acc_next = 8'(wide & keep_mask);
            fill_next     = 3'(extra);
        end else begin
            byte_val      = '0;
            byte_acc_next = wide[7:0];
            fill_next     = fill_sum[2:0];
        end
    end

    always_comb begin
        result.byte_ready = byte_done;
        result.data_byte  = byte_val;
        result.cell_count = 2'(cells);
        result.window_ok  = win;
        result.cell_clock = clock_next;
        result.bits_total = bits_next;
        result.weak_total = weak_next;
    end

    // output buffer control
    always_comb begin
        m_valid_next    = m_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (m_tready || !m_valid_reg) begin
            if (skid_valid_reg) begin
                m_valid_next    = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                m_valid_next = s_accept;
            end
        end else if (s_accept) begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_cell_reg  <= INITIAL_CELL_RST;
            freq_gain_reg  <= FREQ_GAIN_RST;
            phase_gain_reg <= PHASE_GAIN_RST;
            phase_reg      <= '0;
            clock_reg      <= INITIAL_CELL_RST;
            byte_acc_reg   <= '0;
            fill_reg       <= '0;
            bits_reg       <= '0;
            weak_reg       <= '0;
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            init_cell_reg  <= init_cell_next;
            freq_gain_reg  <= freq_gain_next;
            phase_gain_reg <= phase_gain_next;
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
            if (s_accept) begin
                phase_reg    <= phase_next;
                clock_reg    <= clock_next;
                byte_acc_reg <= byte_acc_next;
                fill_reg     <= fill_next;
                bits_reg     <= bits_next;
                weak_reg     <= weak_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (m_tready || !m_valid_reg) begin
            if (skid_valid_reg) begin
                m_data_reg <= skid_data_reg;
            end else if (s_accept) begin
                m_data_reg <= result;
            end
        end else if (s_accept) begin
            skid_data_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_data_reg.byte_ready;
    assign m_tdata  = {5'b0_0000,
                       m_data_reg.weak_total,
                       m_data_reg.bits_total,
                       m_data_reg.cell_clock,
                       m_data_reg.window_ok,
                       m_data_reg.cell_count,
                       m_data_reg.data_byte};

`ifndef SYNTHESIS
    // the skid entry only fills behind a waiting main entry
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid entry valid without main entry");

    // an item taken while the main entry stalls must land in the skid entry
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && m_valid_reg && !m_tready) |=> skid_valid_reg)
        else $error("stalled item lost");

    // cell clock never drops below its saturation minimum
    assert property (@(posedge aclk) disable iff (!aresetn)
        (clock_reg >= CLOCK_MIN))
        else $error("cell clock below minimum");

    // bits above the fill level of the partial byte are always clear
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((byte_acc_reg >> fill_reg) == 8'h00))
        else $error("stray bits in partial byte");
`endif

endmodule
`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for the flux PLL bit assembler: directed table, then random phases.
module tb_top;
    import fpba_pkg::*;

    localparam int        CELL_LIMIT      = 3;
    localparam longint    PHASE_HI        = 64'sd33554431;
    localparam longint    PHASE_LO        = -64'sd33554432;
    localparam int        N_PHASES        = 11;
    localparam int        ITEMS_PER_PHASE = 103;
    localparam int        LONG_HOLD       = 64;
    localparam int        DIR_N           = 22;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam fpba_result_t NO_WANT = '0;

    typedef struct packed {
        logic [15:0]  interval;
        logic         track_start;
        logic         typed;
        fpba_result_t want;
    } dir_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CELL_W-1:0]     cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;   // [15:0] interval
    logic                  s_tuser;   // [0] track_start
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;   // [7:0] byte, [9:8] cells, [10] window, [34:11] clock,
                                      // [66:35] bits, [98:67] weak
    logic                  m_tuser;   // [0] byte_ready

    // separator model state and its copy of the registers
    logic [CELL_W-1:0]  reg_cell;
    logic [GAIN_W-1:0]  reg_fgain;
    logic [GAIN_W-1:0]  reg_pgain;
    longint             pll_phase;
    logic [CELL_W-1:0]  pll_clock;
    logic [7:0]         byte_shift;
    int                 byte_fill;
    logic [COUNT_W-1:0] cells_seen;
    logic [COUNT_W-1:0] weak_seen;

    fpba_result_t pending_decodes[$];
    int           mismatches;
    int           results_seen;
    logic         idle_on;
    logic         hold_req;

    // rows with a typed result are read straight off the nominal 48-tick cell
    dir_row_t dir_rows [DIR_N] = '{
        '{16'd48,    1'b1, 1'b1, '{32'd0, 32'd1, 24'd12288, 1'b1, 2'd1, 8'h00, 1'b0}},
        '{16'd48,    1'b0, 1'b0, NO_WANT},
        '{16'd48,    1'b0, 1'b0, NO_WANT},
        '{16'd48,    1'b0, 1'b0, NO_WANT},
        '{16'd48,    1'b0, 1'b0, NO_WANT},
        '{16'd48,    1'b0, 1'b0, NO_WANT},
        '{16'd48,    1'b0, 1'b0, NO_WANT},
        '{16'd48,    1'b0, 1'b1, '{32'd0, 32'd8, 24'd12288, 1'b1, 2'd1, 8'hFF, 1'b1}},
        '{16'd0,     1'b1, 1'b0, NO_WANT},
        '{16'hFFFF,  1'b1, 1'b0, NO_WANT},
        '{16'd71,    1'b1, 1'b0, NO_WANT},
        '{16'd72,    1'b1, 1'b0, NO_WANT},
        '{16'd119,   1'b1, 1'b0, NO_WANT},
        '{16'd120,   1'b1, 1'b0, NO_WANT},
        '{16'd96,    1'b1, 1'b1, '{32'd0, 32'd2, 24'd12288, 1'b1, 2'd2, 8'h00, 1'b0}},
        '{16'd144,   1'b0, 1'b1, '{32'd0, 32'd5, 24'd12288, 1'b1, 2'd3, 8'h00, 1'b0}},
        '{16'd144,   1'b0, 1'b1, '{32'd0, 32'd8, 24'd12288, 1'b1, 2'd3, 8'h49, 1'b1}},
        '{16'd60,    1'b0, 1'b0, NO_WANT},
        '{16'd84,    1'b0, 1'b0, NO_WANT},
        '{16'hAAAA,  1'b0, 1'b0, NO_WANT},
        '{16'h5555,  1'b0, 1'b0, NO_WANT},
        '{16'd48,    1'b1, 1'b0, NO_WANT}
    };

    flux_pll_bit_assembler dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin : watchdog
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

    // error times gain, rounded half away from zero, 16 fraction bits dropped
    function automatic longint gain_round(input longint e, input logic [GAIN_W-1:0] g);
        longint m;
        m = (e < 0) ? -e : e;
        m = (m * longint'({48'd0, g}) + 64'sd32768) >>> 16;
        return (e < 0) ? -m : m;
    endfunction

    function automatic logic [CELL_W-1:0] clamp_clock(input longint c);
        if (c < longint'({40'd0, CLOCK_MIN}))
            return CLOCK_MIN;
        if (c > longint'({40'd0, CLOCK_MAX}))
            return CLOCK_MAX;
        return c[CELL_W-1:0];
    endfunction

    function automatic logic [COUNT_W-1:0] sat_add32(input logic [COUNT_W-1:0] a,
                                                     input logic [COUNT_W-1:0] b);
        logic [COUNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COUNT_W] ? '1 : s[COUNT_W-1:0];
    endfunction

    function automatic void restart_track();
        pll_clock  = clamp_clock(longint'({40'd0, reg_cell}));
        pll_phase  = 0;
        byte_shift = '0;
        byte_fill  = 0;
        cells_seen = '0;
        weak_seen  = '0;
    endfunction

    function automatic fpba_result_t separate_interval(input logic [15:0] iv, input logic ts);
        fpba_result_t r;
        longint clk, phase, err, mag, nxt, nc;
        logic win;
        r = '0;
        if (ts)
            restart_track();
        clk   = longint'({40'd0, pll_clock});
        phase = pll_phase + (longint'({48'd0, iv}) <<< 8);
        nc    = 1;
        while (nc < CELL_LIMIT && 2 * phase >= (2 * nc + 1) * clk)
            nc++;
        err = phase - nc * clk;
        mag = (err < 0) ? -err : err;
        win = (2 * mag < longint'({40'd0, reg_cell}));
        cells_seen = sat_add32(cells_seen, nc[COUNT_W-1:0]);
        if (!win)
            weak_seen = sat_add32(weak_seen, 32'd1);
        pll_clock = clamp_clock(clk + gain_round(err, reg_fgain));
        nxt = gain_round(err, reg_pgain);
        if (nxt > PHASE_HI)
            nxt = PHASE_HI;
        if (nxt < PHASE_LO)
            nxt = PHASE_LO;
        pll_phase = nxt;
        // cells-1 zeros then a one, MSB first
        for (longint k = 1; k <= nc; k++) begin
            byte_shift = {byte_shift[6:0], (k == nc)};
            byte_fill++;
            if (byte_fill >= 8) begin
                r.byte_ready = 1'b1;
                r.data_byte  = byte_shift;
                byte_shift   = '0;
                byte_fill    = 0;
            end
        end
        r.cell_count = nc[1:0];
        r.window_ok  = win;
        r.cell_clock = pll_clock;
        r.bits_total = cells_seen;
        r.weak_total = weak_seen;
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
        mismatches++;
        $display("mismatch on %s at result %0d: got 0x%0h, want 0x%0h",
                 what, results_seen, got, want);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CELL_W-1:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        case (idx)
            REG_INITIAL_CELL: reg_cell  = val;
            REG_FREQ_GAIN:    reg_fgain = val[GAIN_W-1:0];
            REG_PHASE_GAIN:   reg_pgain = val[GAIN_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_item(input logic [15:0] iv, input logic ts, input logic typed,
                             input fpba_result_t want);
        int gap;
        fpba_result_t pred;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = iv;
        s_tuser  = ts;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        pred = separate_interval(iv, ts);
        pending_decodes.push_back(typed ? want : pred);
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (pending_decodes.size() != 0)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    always @(posedge aclk) begin : watch_results
        fpba_result_t got;
        fpba_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[98:0], m_tuser};
            results_seen++;
            if (pending_decodes.size() == 0) begin
                flag_mismatch("result with nothing pending", 0, 0);
            end else begin
                want = pending_decodes.pop_front();
                if (got.byte_ready !== want.byte_ready)
                    flag_mismatch("byte_ready", got.byte_ready, want.byte_ready);
                if (got.data_byte !== want.data_byte)
                    flag_mismatch("data_byte", got.data_byte, want.data_byte);
                if (got.cell_count !== want.cell_count)
                    flag_mismatch("cell_count", got.cell_count, want.cell_count);
                if (got.window_ok !== want.window_ok)
                    flag_mismatch("window_ok", got.window_ok, want.window_ok);
                if (got.cell_clock !== want.cell_clock)
                    flag_mismatch("cell_clock", got.cell_clock, want.cell_clock);
                if (got.bits_total !== want.bits_total)
                    flag_mismatch("bits_total", got.bits_total, want.bits_total);
                if (got.weak_total !== want.weak_total)
                    flag_mismatch("weak_total", got.weak_total, want.weak_total);
            end
        end
    end

    initial begin : rx_side
        int gap;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            gap = idle_on ? $urandom_range(0, 3) : 0;
            if (hold_req) begin
                gap      = LONG_HOLD;
                hold_req = 1'b0;
            end
            if (gap > 0) begin
                m_tready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready = 1'b1;
            @(posedge aclk);
            while (!m_tvalid)
                @(posedge aclk);
            @(negedge aclk);
        end
    end

    initial begin : stimulus
        logic [CELL_W-1:0] cell_len;
        logic [GAIN_W-1:0] fg;
        logic [GAIN_W-1:0] pg;
        logic [15:0]       iv;
        logic              ts;
        int                cell_t;
        int                sel;
        int                v;
        int                k;

        aresetn      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        idle_on      = 1'b1;
        hold_req     = 1'b0;
        mismatches   = 0;
        results_seen = 0;

        reg_cell  = INITIAL_CELL_RST;
        reg_fgain = FREQ_GAIN_RST;
        reg_pgain = PHASE_GAIN_RST;
        restart_track();

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed rows run on reset defaults
        for (int i = 0; i < DIR_N; i++)
            send_item(dir_rows[i].interval, dir_rows[i].track_start, dir_rows[i].typed,
                      dir_rows[i].want);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            wait_idle();
            case (ph)
                0: begin cell_len = 24'd256;   fg = 16'hFFFF;  pg = 16'hFFFF; end
                1: begin cell_len = CLOCK_MAX; fg = 16'd0;     pg = 16'hFFFF; end
                2: begin cell_len = 24'd0;     fg = 16'hFFFF;  pg = 16'd0;    end
                3: begin cell_len = 24'd1;     fg = 16'd0;     pg = 16'hFFFF; end
                4: begin
                    cell_len = INITIAL_CELL_RST;
                    fg       = FREQ_GAIN_RST;
                    pg       = PHASE_GAIN_RST;
                end
                default: begin
                    cell_len = CELL_W'($urandom_range(8, 400) * 256 + $urandom_range(0, 255));
                    fg   = ($urandom_range(0, 3) == 0) ? GAIN_W'($urandom_range(0, 65535))
                                                       : GAIN_W'($urandom_range(0, 2000));
                    pg   = ($urandom_range(0, 3) == 0) ? GAIN_W'($urandom_range(0, 65535))
                                                       : GAIN_W'($urandom_range(0, 8000));
                end
            endcase
            write_reg(REG_INITIAL_CELL, cell_len);
            // upper data bits are don't-care for the gain registers
            write_reg(REG_FREQ_GAIN, {8'($urandom), fg});
            write_reg(REG_PHASE_GAIN, {8'($urandom), pg});
            if (ph == 4)
                write_reg(REG_UNUSED, CELL_W'($urandom));
            idle_on = (ph % 3 != 0);

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n == 20 && ph % 6 == 0)
                    hold_req = 1'b1;
                if (n == 50 && ph % 4 == 1)
                    wait_idle();
                ts     = (n == 0) || ($urandom_range(0, 39) == 0);
                cell_t = ts ? int'(clamp_clock(longint'({40'd0, reg_cell})) >> 8)
                            : int'(pll_clock >> 8);
                sel    = $urandom_range(0, 19);
                if (sel < 15 && cell_t >= 2 && cell_t <= 20000) begin
                    // jittered run of 1..3 cells around the tracked clock
                    k = $urandom_range(1, 3);
                    v = k * cell_t + int'($urandom_range(0, cell_t / 2)) - cell_t / 4;
                    iv = (v > 65535) ? 16'hFFFF : v[15:0];
                end else if (sel == 17) begin
                    iv = 16'd0;
                end else if (sel == 18) begin
                    iv = 16'hFFFF;
                end else begin
                    iv = 16'($urandom);
                end
                send_item(iv, ts, 1'b0, NO_WANT);
            end
        end

        wait_idle();
        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: sim.f
rtl/fpba_pkg.sv
rtl/flux_pll_bit_assembler.sv
tb/tb_top.sv
